// ===== rtl/dmes_pkg.sv =====
// Shared constants and types for the delayed MIDI event slot ring.
package dmes_pkg;

  localparam int SLOT_COUNT  = 16;
  localparam int DELAY_BITS  = 16;
  localparam int MAX_RESULTS = 16;

  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W  = SLOT_W + 1;
  localparam int RES_W  = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] KIND_NOTE_ON  = 2'd0;
  localparam logic [1:0] KIND_NOTE_OFF = 2'd1;
  localparam logic [1:0] KIND_PROGRAM  = 2'd2;
  localparam logic [1:0] KIND_SILENT   = 2'd3;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef struct packed {
    logic [1:0]            kind;
    logic [3:0]            channel;
    logic [6:0]            first;
    logic [6:0]            second;
    logic [DELAY_BITS-1:0] countdown;
  } slot_t;

endpackage

// ===== rtl/dmes_slot_ram.sv =====
// Slot store: one write port, one registered read port, per-entry valid bits.
module dmes_slot_ram (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    wr_en,
  input  logic [dmes_pkg::SLOT_W-1:0] wr_addr,
  input  dmes_pkg::slot_t         wr_data,
  input  logic                    rd_en,
  input  logic [dmes_pkg::SLOT_W-1:0] rd_addr,
  output dmes_pkg::slot_t         rd_data
);
  import dmes_pkg::*;

  slot_t                 mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= valid[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  // unwritten entries read as idle
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

endmodule

// ===== rtl/delayed_midi_event_slots.sv =====
// Top level: ring of delayed MIDI event slots with tick scan sequencer.
//
//  channel  signals                                                 dir
//  -------  ------------------------------------------------------  ---
//  in       in_valid in_ready command event_kind midi_channel        in
//           first_data second_data delay_ticks
//  out      out_valid out_ready out_kind out_channel out_first       out
//           out_second last_of_tick
//
// An add request writes its slot straight from idle. A tick request walks the slot
// memory one slot per cycle through the single read port, unless the scan stalls.
// Fired events pass through a one-entry hold register so the last one of a
// tick can be marked, then through the output register.
// The scan stalls only while both of those are full and out_ready is low.
// Reset clears the valid bits of the store at once; no clearing pass.
module delayed_midi_event_slots (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [1:0]  event_kind,
  input  logic [3:0]  midi_channel,
  input  logic [6:0]  first_data,
  input  logic [6:0]  second_data,
  input  logic [15:0] delay_ticks,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [3:0]  out_channel,
  output logic [6:0]  out_first,
  output logic [6:0]  out_second,
  output logic        last_of_tick
);
  import dmes_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] channel;
    logic [6:0] first;
    logic [6:0] second;
  } event_t;

  state_t            state, state_next;
  logic [SLOT_W-1:0] write_slot, write_slot_next;
  logic [CNT_W-1:0]  issue_cnt, issue_cnt_next;
  logic [RES_W-1:0]  res_cnt, res_cnt_next;
  logic              proc_vld, proc_vld_next;
  logic [SLOT_W-1:0] proc_idx, proc_idx_next;
  logic              pend_vld, pend_vld_next;
  event_t            pend, pend_next;
  event_t            out_ev, out_ev_next;
  logic              out_last, out_last_next;
  logic              out_vld_next;

  logic              wr_en, rd_en;
  logic [SLOT_W-1:0] wr_addr, rd_addr;
  slot_t             wr_data, rd_data;

  logic                  in_fire, out_free, fire, stall;
  logic [DELAY_BITS-1:0] cnt_dec;
  event_t                fire_ev;

  dmes_slot_ram u_ram (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign cnt_dec  = rd_data.countdown - DELAY_BITS'(1);

  assign fire = proc_vld && (rd_data.countdown != '0) && (cnt_dec == '0) &&
                (rd_data.kind != KIND_SILENT) && (res_cnt < RES_W'(MAX_RESULTS));
  assign stall = fire && pend_vld && !out_free;

  always_comb begin
    fire_ev.kind    = rd_data.kind;
    fire_ev.channel = rd_data.channel;
    fire_ev.first   = rd_data.first;
    fire_ev.second  = (rd_data.kind == KIND_PROGRAM) ? 7'd0 : rd_data.second;
  end

  always_comb begin
    state_next      = state;
    write_slot_next = write_slot;
    issue_cnt_next  = issue_cnt;
    res_cnt_next    = res_cnt;
    proc_vld_next   = proc_vld;
    proc_idx_next   = proc_idx;
    pend_vld_next   = pend_vld;
    pend_next       = pend;
    out_ev_next     = out_ev;
    out_last_next   = out_last;
    out_vld_next    = out_valid && !out_ready;
    wr_en           = 1'b0;
    wr_addr         = proc_idx;
    wr_data         = rd_data;
    rd_en           = 1'b0;
    rd_addr         = issue_cnt[SLOT_W-1:0];

    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (command == CMD_ADD) begin
            wr_en             = 1'b1;
            wr_addr           = write_slot;
            wr_data.kind      = event_kind;
            wr_data.channel   = midi_channel;
            wr_data.first     = first_data;
            wr_data.second    = second_data;
            wr_data.countdown = DELAY_BITS'(delay_ticks);
            write_slot_next   = (write_slot == SLOT_W'(SLOT_COUNT - 1)) ?
                                '0 : write_slot + SLOT_W'(1);
          end else begin
            issue_cnt_next = '0;
            res_cnt_next   = '0;
            proc_vld_next  = 1'b0;
            state_next     = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (!stall) begin
          rd_en         = (issue_cnt != CNT_W'(SLOT_COUNT));
          proc_vld_next = rd_en;
          proc_idx_next = rd_addr;
          if (rd_en) begin
            issue_cnt_next = issue_cnt + CNT_W'(1);
          end
          if (proc_vld && (rd_data.countdown != '0)) begin
            wr_en             = 1'b1;
            wr_data.countdown = cnt_dec;
          end
          if (fire) begin
            res_cnt_next  = res_cnt + RES_W'(1);
            pend_vld_next = 1'b1;
            pend_next     = fire_ev;
            if (pend_vld) begin
              out_ev_next   = pend;
              out_last_next = 1'b0;
              out_vld_next  = 1'b1;
            end
          end
          if (!rd_en) begin
            state_next = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_vld) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          out_ev_next   = pend;
          out_last_next = 1'b1;
          out_vld_next  = 1'b1;
          pend_vld_next = 1'b0;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    pend     <= pend_next;
    out_ev   <= out_ev_next;
    out_last <= out_last_next;
    proc_idx <= proc_idx_next;
    if (rst) begin
      state      <= ST_IDLE;
      write_slot <= '0;
      issue_cnt  <= '0;
      res_cnt    <= '0;
      proc_vld   <= 1'b0;
      pend_vld   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      write_slot <= write_slot_next;
      issue_cnt  <= issue_cnt_next;
      res_cnt    <= res_cnt_next;
      proc_vld   <= proc_vld_next;
      pend_vld   <= pend_vld_next;
      out_valid  <= out_vld_next;
    end
  end

  assign out_kind     = out_ev.kind;
  assign out_channel  = out_ev.channel;
  assign out_first    = out_ev.first;
  assign out_second   = out_ev.second;
  assign last_of_tick = out_last;

endmodule

// ===== test/midi_slot_checker.sv =====
// Checker for the delayed MIDI event slot ring: predicts fired events and compares.
`timescale 1ns / 100ps

module midi_slot_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        command,
  input  logic [1:0]  event_kind,
  input  logic [3:0]  midi_channel,
  input  logic [6:0]  first_data,
  input  logic [6:0]  second_data,
  input  logic [15:0] delay_ticks,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_kind,
  input  logic [3:0]  out_channel,
  input  logic [6:0]  out_first,
  input  logic [6:0]  out_second,
  input  logic        last_of_tick,
  output int          mismatches,
  output int          waiting
);
  import dmes_pkg::*;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] channel;
    logic [6:0] first;
    logic [6:0] second;
    logic       last;
  } fired_event_t;

  slot_t        event_ring [SLOT_COUNT];
  int           next_slot;
  fired_event_t due_events [$];
  int           err_total = 0;
  int           queued = 0;

  assign mismatches = err_total;
  assign waiting    = queued;

  always @(posedge clk) begin
    fired_event_t want;
    fired_event_t got;
    int           fired;
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) event_ring[i] = '0;
      next_slot = 0;
      due_events.delete();
    end else begin
      if (in_valid && in_ready) begin
        if (command == CMD_ADD) begin
          event_ring[next_slot].kind      = event_kind;
          event_ring[next_slot].channel   = midi_channel;
          event_ring[next_slot].first     = first_data;
          event_ring[next_slot].second    = second_data;
          event_ring[next_slot].countdown = DELAY_BITS'(delay_ticks);
          next_slot = (next_slot + 1) % SLOT_COUNT;
        end else begin
          fired = 0;
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (event_ring[i].countdown != '0) begin
              event_ring[i].countdown = event_ring[i].countdown - 1'b1;
              if (event_ring[i].countdown == '0 && event_ring[i].kind != KIND_SILENT &&
                  fired < MAX_RESULTS) begin
                want.kind    = event_ring[i].kind;
                want.channel = event_ring[i].channel;
                want.first   = event_ring[i].first;
                want.second  = (event_ring[i].kind == KIND_PROGRAM) ? 7'd0 :
                               event_ring[i].second;
                want.last    = 1'b0;
                due_events.push_back(want);
                fired++;
              end
            end
          end
          if (fired > 0) begin
            want = due_events.pop_back();
            want.last = 1'b1;
            due_events.push_back(want);
          end
        end
      end
      if (out_valid && out_ready) begin
        got = '{out_kind, out_channel, out_first, out_second, last_of_tick};
        if (due_events.size() == 0) begin
          err_total++;
          if (err_total <= 10)
            $display("%0t: unexpected event kind=%0d ch=%0d first=%0d second=%0d last=%0d",
                     $realtime, got.kind, got.channel, got.first, got.second, got.last);
        end else begin
          want = due_events.pop_front();
          if (got !== want) begin
            err_total++;
            if (err_total <= 10) begin
              $write("%0t: mismatch expected kind=%0d ch=%0d first=%0d second=%0d last=%0d",
                     $realtime, want.kind, want.channel, want.first, want.second,
                     want.last);
              $display(", got kind=%0d ch=%0d first=%0d second=%0d last=%0d",
                       got.kind, got.channel, got.first, got.second, got.last);
            end
          end
        end
      end
    end
    queued = due_events.size();
  end

endmodule

// ===== test/testbench.sv =====
// Testbench top: clock, reset, request stimulus and verdict for the event slot ring.
`timescale 1ns / 100ps

module testbench;
  import dmes_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        command;
  logic [1:0]  event_kind;
  logic [3:0]  midi_channel;
  logic [6:0]  first_data;
  logic [6:0]  second_data;
  logic [15:0] delay_ticks;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_kind;
  logic [3:0]  out_channel;
  logic [6:0]  out_first;
  logic [6:0]  out_second;
  logic        last_of_tick;
  logic        no_idle;
  int          mismatches;
  int          waiting;

  delayed_midi_event_slots dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .command(command),
    .event_kind(event_kind), .midi_channel(midi_channel), .first_data(first_data),
    .second_data(second_data), .delay_ticks(delay_ticks),
    .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind),
    .out_channel(out_channel), .out_first(out_first), .out_second(out_second),
    .last_of_tick(last_of_tick)
  );

  midi_slot_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .command(command),
    .event_kind(event_kind), .midi_channel(midi_channel), .first_data(first_data),
    .second_data(second_data), .delay_ticks(delay_ticks),
    .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind),
    .out_channel(out_channel), .out_first(out_first), .out_second(out_second),
    .last_of_tick(last_of_tick), .mismatches(mismatches), .waiting(waiting)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  task automatic push_request(input logic cmd, input logic [1:0] kind, input logic [3:0] ch,
                              input logic [6:0] f, input logic [6:0] s,
                              input logic [15:0] d);
    int gap;
    in_valid     <= 1'b1;
    command      <= cmd;
    event_kind   <= kind;
    midi_channel <= ch;
    first_data   <= f;
    second_data  <= s;
    delay_ticks  <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    gap = no_idle ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic add_event(input logic [1:0] kind, input logic [3:0] ch, input logic [6:0] f,
                           input logic [6:0] s, input logic [15:0] d);
    push_request(CMD_ADD, kind, ch, f, s, d);
  endtask

  // tick payload is ignored by the block, so it is random
  task automatic tick();
    push_request(CMD_TICK, 2'($urandom()), 4'($urandom()), 7'($urandom()),
                 7'($urandom()), 16'($urandom()));
  endtask

  // receiver: ready runs and stalls of random length; under no_idle, ready stays high
  initial begin
    int n;
    out_ready = 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      n = no_idle ? 50 : $urandom_range(1, 20);
      repeat (n) @(posedge clk);
      if (!no_idle) begin
        n = idle_len();
        if (n > 0) begin
          out_ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end
    end
  end

  initial begin
    int r;
    logic [15:0] d;
    in_valid     = 1'b0;
    command      = CMD_ADD;
    event_kind   = KIND_NOTE_ON;
    midi_channel = '0;
    first_data   = '0;
    second_data  = '0;
    delay_ticks  = '0;
    no_idle      = 1'b0;
    rst          = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed
    tick();                                              // idle tick on empty ring
    add_event(KIND_NOTE_ON, 4'd0, 7'd0, 7'd0, 16'd1);
    add_event(KIND_NOTE_OFF, 4'd15, 7'd127, 7'd127, 16'd1);
    add_event(KIND_PROGRAM, 4'd5, 7'd127, 7'd127, 16'd2); // second forced to zero
    add_event(KIND_SILENT, 4'd10, 7'd85, 7'd42, 16'd1);
    add_event(KIND_NOTE_ON, 4'd3, 7'd60, 7'd100, 16'd0);  // zero delay, never fires
    add_event(KIND_NOTE_ON, 4'd7, 7'd1, 7'd2, 16'hFFFF);
    add_event(KIND_NOTE_OFF, 4'd8, 7'd64, 7'd64, 16'h8000);
    tick();
    tick();
    // fill whole ring, overwriting the long pending slots, then fire all at once
    for (int k = 0; k < SLOT_COUNT; k++)
      add_event(2'(k % 3), 4'(k), 7'($urandom()), 7'($urandom()), 16'd1);
    tick();

    // random
    for (int k = 0; k < 450; k++) begin
      if (k % 60 == 0) no_idle <= ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 40) begin
        tick();
      end else begin
        r = $urandom_range(0, 99);
        if (r < 5) d = 16'd0;
        else if (r < 10) d = 16'($urandom());
        else d = 16'($urandom_range(1, 6));
        add_event(2'($urandom()), 4'($urandom()), 7'($urandom()), 7'($urandom()), d);
      end
    end
    in_valid <= 1'b0;
    no_idle  <= 1'b0;

    do @(posedge clk); while (waiting != 0);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && waiting == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
